// ===== rtl/cqgp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqgp_pkg
// Types, constants and rounding helper for the controlled qubit gate pair
// update block.
// ----------------------------------------------------------------------------
package cqgp_pkg;

  // number of qubits in the state vector; indices wrap at this width
  localparam int STATE_QUBITS = 16;
  localparam int IDX_W        = 16;
  localparam int PAIR_W       = 15;
  localparam int AMP_W        = 16;
  localparam int COEFF_W      = 32;
  localparam int PROD_W       = 2 * AMP_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int FRAC_W       = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [IDX_W-1:0] IDX_MASK =
    (STATE_QUBITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << STATE_QUBITS) - 64'd1);

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_00   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_01   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_10   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_11   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_MODE = 3'd6;

  // reset values
  localparam logic [COEFF_W-1:0] COEFF_ONE   = 32'h4000_0000;
  localparam logic [COEFF_W-1:0] COEFF_ZERO  = 32'h0000_0000;
  localparam logic [4:0]         CONTROL_OFF = 5'h1F;

  // result action codes
  localparam logic [1:0] ACT_KERNEL = 2'd0;
  localparam logic [1:0] ACT_ZERO   = 2'd1;
  localparam logic [1:0] ACT_PASS   = 2'd2;

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_number;
    amp_t              low_real;
    amp_t              low_imag;
    amp_t              high_real;
    amp_t              high_imag;
  } pair_t;

  typedef struct packed {
    logic [IDX_W-1:0] low_index;
    logic [IDX_W-1:0] high_index;
    amp_t             new_low_real;
    amp_t             new_low_imag;
    amp_t             new_high_real;
    amp_t             new_high_imag;
    logic [1:0]       action;
  } result_t;

  // round half up on the Q2.28 sum, back to Q1.14, then saturate
  function automatic amp_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]        v;
    logic signed [ACC_W-FRAC_W:0] q;
    amp_t                         r;
    v = (ACC_W+1)'(acc) + (ACC_W+1)'(signed'(1 << (FRAC_W - 1)));
    q = v[ACC_W:FRAC_W];
    if (q > (ACC_W-FRAC_W+1)'(signed'(32767))) begin
      r = 16'sh7FFF;
    end else if (q < -(ACC_W-FRAC_W+1)'(signed'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = q[AMP_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cqgp_row.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqgp_row
// One kernel row: out = k_lo*lo + k_hi*hi in complex Q1.14. Eight products
// are registered, then summed, rounded and saturated combinationally.
// ----------------------------------------------------------------------------
module cqgp_row (
  input  wire logic                          clk,
  input  wire logic [cqgp_pkg::COEFF_W-1:0]  k_lo,
  input  wire logic [cqgp_pkg::COEFF_W-1:0]  k_hi,
  input  wire cqgp_pkg::amp_t                lo_re,
  input  wire cqgp_pkg::amp_t                lo_im,
  input  wire cqgp_pkg::amp_t                hi_re,
  input  wire cqgp_pkg::amp_t                hi_im,
  output cqgp_pkg::amp_t                     new_re,
  output cqgp_pkg::amp_t                     new_im
);
  import cqgp_pkg::*;

  amp_t kl_re, kl_im, kh_re, kh_im;
  logic signed [PROD_W-1:0] p_re0, p_re1, p_re2, p_re3;
  logic signed [PROD_W-1:0] p_im0, p_im1, p_im2, p_im3;
  logic signed [ACC_W-1:0]  acc_re, acc_im;

  assign kl_re = amp_t'(k_lo[COEFF_W-1:AMP_W]);
  assign kl_im = amp_t'(k_lo[AMP_W-1:0]);
  assign kh_re = amp_t'(k_hi[COEFF_W-1:AMP_W]);
  assign kh_im = amp_t'(k_hi[AMP_W-1:0]);

  always_ff @(posedge clk) begin
    p_re0 <= kl_re * lo_re;
    p_re1 <= kl_im * lo_im;
    p_re2 <= kh_re * hi_re;
    p_re3 <= kh_im * hi_im;
    p_im0 <= kl_re * lo_im;
    p_im1 <= kl_im * lo_re;
    p_im2 <= kh_re * hi_im;
    p_im3 <= kh_im * hi_re;
  end

  // sums are exact in 34 bits
  assign acc_re = ACC_W'(p_re0) - ACC_W'(p_re1) + ACC_W'(p_re2) - ACC_W'(p_re3);
  assign acc_im = ACC_W'(p_im0) + ACC_W'(p_im1) + ACC_W'(p_im2) + ACC_W'(p_im3);

  assign new_re = round_sat(acc_re);
  assign new_im = round_sat(acc_im);

endmodule
`default_nettype wire

// ===== rtl/controlled_qubit_gate_pair_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// controlled_qubit_gate_pair_update
// Applies a configured 2x2 complex kernel to one amplitude pair of a state
// vector, gated by an optional control qubit.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle; busy is never raised, the pipeline has no
// back-pressure and the receiver cannot stall the result strobe.
// Pipeline: input register, product register (16 multipliers), result register.
// Reset: synchronous, clears the valid pipeline and loads the kernel with the
// identity, target bit 0, no control and normal mode.
// ----------------------------------------------------------------------------
module controlled_qubit_gate_pair_update (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cqgp_pkg::pair_t                 pair,
  // result channel
  output logic                                 done,
  output cqgp_pkg::result_t                    result,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cqgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cqgp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cqgp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken in any cycle; indices past the
  // list are dropped.
  // --------------------------------------------------------------------------
  logic [COEFF_W-1:0] coeff [4];
  logic [3:0]         target_bit;
  logic [4:0]         control_bit;
  logic               derivative_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff[0]        <= COEFF_ONE;
      coeff[1]        <= COEFF_ZERO;
      coeff[2]        <= COEFF_ZERO;
      coeff[3]        <= COEFF_ONE;
      target_bit      <= 4'd0;
      control_bit     <= CONTROL_OFF;
      derivative_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        CFG_COEFF_00, CFG_COEFF_01, CFG_COEFF_10, CFG_COEFF_11: begin
          coeff[cfg_index[1:0]] <= cfg_data;
        end
        CFG_TARGET_BIT: begin
          target_bit <= cfg_data[3:0];
        end
        CFG_CONTROL: begin
          control_bit <= cfg_data[4:0];
        end
        CFG_DERIV_MODE: begin
          derivative_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register. Every start transaction is taken.
  // --------------------------------------------------------------------------
  assign busy = 1'b0;

  logic  valid_a;
  pair_t pair_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pair_a <= pair;
    end
  end

  // --------------------------------------------------------------------------
  // Index formation: insert a zero at the target bit, wrap to the vector
  // size. A target past the vector loses the inserted bit, so both indices
  // come out equal.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] pair_ext, below_mask, lo_idx, hi_idx;
  logic             ctrl_ok;
  logic [1:0]       action_a;

  assign pair_ext   = IDX_W'(pair_a.pair_number);
  assign below_mask = (IDX_W'(1) << target_bit) - IDX_W'(1);
  assign lo_idx     = (((pair_ext & ~below_mask) << 1) | (pair_ext & below_mask)) & IDX_MASK;
  assign hi_idx     = (lo_idx | (IDX_W'(1) << target_bit)) & IDX_MASK;

  // sign bit of the control register means no control; otherwise test the
  // lower index (fails when control equals target)
  assign ctrl_ok = control_bit[4] || lo_idx[control_bit[3:0]];

  always_comb begin
    if (ctrl_ok) begin
      action_a = ACT_KERNEL;
    end else if (derivative_mode) begin
      action_a = ACT_ZERO;
    end else begin
      action_a = ACT_PASS;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: products (inside the row units) plus side data.
  // --------------------------------------------------------------------------
  logic             valid_b;
  logic [IDX_W-1:0] lo_idx_b, hi_idx_b;
  logic [1:0]       action_b;
  pair_t            pair_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    lo_idx_b <= lo_idx;
    hi_idx_b <= hi_idx;
    action_b <= action_a;
    pair_b   <= pair_a;
  end

  amp_t row0_re, row0_im, row1_re, row1_im;

  cqgp_row u_row0 (
    .clk    (clk),
    .k_lo   (coeff[0]),
    .k_hi   (coeff[1]),
    .lo_re  (pair_a.low_real),
    .lo_im  (pair_a.low_imag),
    .hi_re  (pair_a.high_real),
    .hi_im  (pair_a.high_imag),
    .new_re (row0_re),
    .new_im (row0_im)
  );

  cqgp_row u_row1 (
    .clk    (clk),
    .k_lo   (coeff[2]),
    .k_hi   (coeff[3]),
    .lo_re  (pair_a.low_real),
    .lo_im  (pair_a.low_imag),
    .hi_re  (pair_a.high_real),
    .hi_im  (pair_a.high_imag),
    .new_re (row1_re),
    .new_im (row1_im)
  );

  // --------------------------------------------------------------------------
  // Stage C: pick kernel output, zeros or the untouched inputs; register it.
  // --------------------------------------------------------------------------
  result_t result_next;

  always_comb begin
    result_next.low_index  = lo_idx_b;
    result_next.high_index = hi_idx_b;
    result_next.action     = action_b;
    case (action_b)
      ACT_KERNEL: begin
        result_next.new_low_real  = row0_re;
        result_next.new_low_imag  = row0_im;
        result_next.new_high_real = row1_re;
        result_next.new_high_imag = row1_im;
      end
      ACT_ZERO: begin
        result_next.new_low_real  = '0;
        result_next.new_low_imag  = '0;
        result_next.new_high_real = '0;
        result_next.new_high_imag = '0;
      end
      default: begin
        result_next.new_low_real  = pair_b.low_real;
        result_next.new_low_imag  = pair_b.low_imag;
        result_next.new_high_real = pair_b.high_real;
        result_next.new_high_imag = pair_b.high_imag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

// ===== dv/cqgp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqgp_checker
// Watches the item, result and configuration channels of the controlled qubit
// gate pair update block. It keeps its own copy of the registers, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module cqgp_checker
  import cqgp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  pair_t                 pair,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // shadow registers
  logic [COEFF_W-1:0] kern [4];
  logic [3:0]         tgt;
  logic [4:0]         ctrl;
  logic               deriv;

  result_t expected_q [$];
  int      errors = 0;

  assign fail_count = errors;

  function automatic longint part_re(int k);
    return longint'($signed(kern[k][31:16]));
  endfunction

  function automatic longint part_im(int k);
    return longint'($signed(kern[k][15:0]));
  endfunction

  // Q2.28 sum back to Q1.14: round half up, then clamp
  function automatic amp_t q14_round(longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return amp_t'(q);
  endfunction

  // one output row: k0 * lo + k1 * hi, k1 = k0 + 1
  function automatic void mix_row(input int k0, input pair_t p,
                                  output amp_t re_o, output amp_t im_o);
    longint lr, li, hr, hi, acc_re, acc_im;
    lr = p.low_real;
    li = p.low_imag;
    hr = p.high_real;
    hi = p.high_imag;
    acc_re = part_re(k0) * lr - part_im(k0) * li
           + part_re(k0 + 1) * hr - part_im(k0 + 1) * hi;
    acc_im = part_re(k0) * li + part_im(k0) * lr
           + part_re(k0 + 1) * hi + part_im(k0 + 1) * hr;
    re_o = q14_round(acc_re);
    im_o = q14_round(acc_im);
  endfunction

  function automatic result_t predict_update(pair_t p);
    logic [31:0] vmask, below, lo, hi;
    logic        ok;
    result_t     r;
    vmask = (32'd1 << STATE_QUBITS) - 32'd1;
    below = 32'(p.pair_number) & ((32'd1 << tgt) - 32'd1);
    lo    = (((32'(p.pair_number) >> tgt) << (32'(tgt) + 1)) | below) & vmask;
    hi    = (lo | (32'd1 << tgt)) & vmask;
    // bit 4 set means no control qubit
    ok    = ctrl[4] || lo[ctrl[3:0]];
    r.low_index  = IDX_W'(lo);
    r.high_index = IDX_W'(hi);
    if (ok) begin
      mix_row(0, p, r.new_low_real, r.new_low_imag);
      mix_row(2, p, r.new_high_real, r.new_high_imag);
      r.action = ACT_KERNEL;
    end else if (deriv) begin
      r.new_low_real  = '0;
      r.new_low_imag  = '0;
      r.new_high_real = '0;
      r.new_high_imag = '0;
      r.action        = ACT_ZERO;
    end else begin
      r.new_low_real  = p.low_real;
      r.new_low_imag  = p.low_imag;
      r.new_high_real = p.high_real;
      r.new_high_imag = p.high_imag;
      r.action        = ACT_PASS;
    end
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      kern[0] = COEFF_ONE;
      kern[1] = COEFF_ZERO;
      kern[2] = COEFF_ZERO;
      kern[3] = COEFF_ONE;
      tgt     = '0;
      ctrl    = CONTROL_OFF;
      deriv   = 1'b0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no pair outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          compare_field("low_index", want.low_index, result.low_index);
          compare_field("high_index", want.high_index, result.high_index);
          compare_field("new_low_real", want.new_low_real, result.new_low_real);
          compare_field("new_low_imag", want.new_low_imag, result.new_low_imag);
          compare_field("new_high_real", want.new_high_real, result.new_high_real);
          compare_field("new_high_imag", want.new_high_imag, result.new_high_imag);
          compare_field("action", want.action, result.action);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COEFF_00, CFG_COEFF_01,
          CFG_COEFF_10, CFG_COEFF_11: kern[cfg_index[1:0]] = cfg_data;
          CFG_TARGET_BIT:             tgt   = cfg_data[3:0];
          CFG_CONTROL:                ctrl  = cfg_data[4:0];
          CFG_DERIV_MODE:             deriv = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(predict_update(pair));
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/tb_controlled_qubit_gate_pair_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_controlled_qubit_gate_pair_update
// Drives amplitude pairs and register writes into the pair update block and
// leaves prediction and comparison to the checker beside it. A short directed
// part covers the extremes, rounding, saturation and the control cases; the
// random part runs bursts of pairs over many kernel settings.
// ----------------------------------------------------------------------------
module tb_controlled_qubit_gate_pair_update;
  import cqgp_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int PHASES        = 10;
  localparam int PAIRS_PER_SET = 175;
  // pipeline is three deep; a few spare cycles after the last result
  localparam int DRAIN_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  pair_t                 pair;
  logic                  done;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  controlled_qubit_gate_pair_update dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pair      (pair),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cqgp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pair       (pair),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // --------------------------------------------------------------------------
  // random content
  // --------------------------------------------------------------------------

  // biased towards the rails so saturation and sign handling get exercised
  function automatic amp_t rand_amp();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return amp_t'(int'($urandom_range(0, 32768)) - 16384);
      default: return amp_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    case ($urandom_range(0, 15))
      0:       p.pair_number = '0;
      1:       p.pair_number = '1;
      default: p.pair_number = PAIR_W'($urandom);
    endcase
    p.low_real  = rand_amp();
    p.low_imag  = rand_amp();
    p.high_real = rand_amp();
    p.high_imag = rand_amp();
    return p;
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff();
    logic [15:0] rails [4];
    rails = '{16'h7FFF, 16'h8000, 16'h0000, 16'h4000};
    case ($urandom_range(0, 3))
      0:       return {rails[$urandom_range(0, 3)], rails[$urandom_range(0, 3)]};
      1:       return {16'($urandom_range(0, 32768) - 16384),
                       16'($urandom_range(0, 32768) - 16384)};
      default: return $urandom;
    endcase
  endfunction

  function automatic pair_t make_pair(logic [PAIR_W-1:0] n, int lr, int li,
                                      int hr, int hi);
    return '{pair_number: n, low_real: amp_t'(lr), low_imag: amp_t'(li),
             high_real: amp_t'(hr), high_imag: amp_t'(hi)};
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers: change on the falling edge, handshake seen on the rising
  // --------------------------------------------------------------------------

  // start stays high on return so back-to-back pairs need no re-raise
  task automatic push_pair(pair_t p);
    @(negedge clk);
    start <= 1'b1;
    pair  <= p;
    do @(posedge clk); while (busy);
  endtask

  // idle cycles; the item bus carries junk that must be ignored
  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      pair  <= rand_pair();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop both channels and wait until every outstanding pair has come back;
  // each pair gives exactly one result, so the block is idle after that
  task automatic settle();
    @(negedge clk);
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apply_setting(logic [COEFF_W-1:0] k00, logic [COEFF_W-1:0] k01,
                               logic [COEFF_W-1:0] k10, logic [COEFF_W-1:0] k11,
                               logic [31:0] tgt_w, logic [31:0] ctrl_w,
                               logic [31:0] deriv_w);
    settle();
    write_reg(CFG_COEFF_00, k00);
    write_reg(CFG_COEFF_01, k01);
    write_reg(CFG_COEFF_10, k10);
    write_reg(CFG_COEFF_11, k11);
    write_reg(CFG_TARGET_BIT, tgt_w);
    write_reg(CFG_CONTROL, ctrl_w);
    write_reg(CFG_DERIV_MODE, deriv_w);
    settle();
  endtask

  // bursts of random length, gaps of random length, some bursts run straight on
  task automatic run_bursts(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        push_pair(rand_pair());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] ctrl_w;
    rst       <= 1'b1;
    start     <= 1'b0;
    pair      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: identity kernel, no control
    push_pair(make_pair(15'h0000, 0, 0, 0, 0));
    push_pair(make_pair(15'h7FFF, 32767, -32768, -32768, 32767));
    push_pair(make_pair(15'h5555, 8192, -8192, -8193, 1));

    // largest kernel, target at the top, surplus register bits must be dropped;
    // the spare index write must leave everything alone
    apply_setting(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'h0000_0000);
    settle();
    push_pair(make_pair(15'h7FFF, 32767, 32767, 32767, 32767));
    push_pair(make_pair(15'h7FFF, -32768, -32768, -32768, -32768));
    push_pair(make_pair(15'h2AAA, 32767, -32768, 32767, -32768));

    // control on the target qubit never fires: zeroed in derivative mode
    apply_setting(32'h8000_0000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                  32'h0000_0013, 32'hFFFF_FFE3, 32'h0000_0001);
    push_pair(make_pair(15'h7FFF, 32767, -32768, 123, -456));
    push_pair(make_pair(15'h1234, -32768, 32767, -1, 1));

    // same, normal mode: amplitudes pass through untouched
    apply_setting(32'h8000_0000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                  32'h0000_0003, 32'h0000_0003, 32'hFFFF_FFFE);
    push_pair(make_pair(15'h7FFF, 32767, -32768, 32767, -32768));
    push_pair(make_pair(15'h0000, -32768, 32767, -32768, 32767));

    // one-LSB kernel entries: rounding at exactly half, just below and above;
    // control on the top qubit, so only pairs with bit 14 set get the kernel
    apply_setting(32'h0001_0000, 32'h0000_0001, 32'hFFFF_0000, 32'h0000_FFFF,
                  32'h0000_0000, 32'h0000_000F, 32'h0000_0001);
    push_pair(make_pair(15'h4000, 8192, 0, 0, 0));
    push_pair(make_pair(15'h4000, -8192, 0, 0, 0));
    push_pair(make_pair(15'h4000, -8193, 0, 0, 0));
    push_pair(make_pair(15'h4001, 8191, 8192, -8192, 16384));
    push_pair(make_pair(15'h0001, 8192, 8192, 8192, 8192));
    push_pair(make_pair(15'h3FFF, -1, -1, -1, -1));

    // random part; the first two settings are the corners
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        apply_setting(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                      32'h0000_0000, 32'h0000_000F, 32'h0000_0001);
      end else if (ph == 1) begin
        apply_setting(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                      32'h0000_000F, 32'h0000_0000, 32'h0000_0000);
      end else begin
        // one setting in four has no control qubit (bit 4 set)
        if ($urandom_range(0, 3) == 0) ctrl_w = $urandom | 32'h10;
        else ctrl_w = ($urandom & ~32'h1F) | $urandom_range(0, 15);
        apply_setting(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                      ($urandom & ~32'hF) | $urandom_range(0, 15), ctrl_w, $urandom);
      end
      run_bursts(PAIRS_PER_SET);
    end

    settle();
    pause(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("** controlled_qubit_gate_pair_update: PASSED **");
    end else begin
      $display("** controlled_qubit_gate_pair_update: FAILED **");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** controlled_qubit_gate_pair_update: FAILED **");
    $finish;
  end

endmodule
